>>> hdl/lpr_pkg.sv
package lpr_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int NUM_IFACES  = 16;

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int IP_W    = 32;
  localparam int LEN_W   = 6;
  localparam int IFACE_W = 4;
  localparam int TTL_W   = 8;
  localparam int STAT_W  = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(IP_W);
  localparam logic [TTL_W-1:0] MIN_TTL = TTL_W'(2);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED        = 3'd0,
    ST_FORWARDED    = 3'd1,
    ST_DROP_TTL     = 3'd2,
    ST_DROP_NOROUTE = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef struct packed {
    logic [IP_W-1:0]    prefix;
    logic [LEN_W-1:0]   length;
    logic               has_hop;
    logic [IP_W-1:0]    hop_addr;
    logic [IFACE_W-1:0] iface;
  } entry_t;

  // high-order mask for a prefix length of 0..32
  function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~({IP_W{1'b1}} >> len);
  endfunction

endpackage

>>> hdl/lpr_table.sv
module lpr_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [lpr_pkg::ADDR_W-1:0]  wr_addr,
  input  lpr_pkg::entry_t             wr_data,
  input  logic                        rd_en,
  input  logic [lpr_pkg::ADDR_W-1:0]  rd_addr,
  output lpr_pkg::entry_t             rd_data
);

  lpr_pkg::entry_t mem [lpr_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/longest_prefix_route_lookup_core.sv
// Longest-prefix-match route table and forwarding decision.
//
// Commands enter on start while busy is low; cmd selects add-route or
// route-datagram. Every transaction gives exactly one result, shown on
// status/out_iface/hop_addr/ttl_out for one cycle with done high. The
// receiver cannot stall; done and busy are never high together, so a new
// command may be issued in the cycle done is shown.
//
// Add route, and a datagram dropped for TTL below 2: result is registered in
// the cycle after the command; busy stays low.
// Route lookup: the table is scanned one entry per cycle through its single
// registered read port, and the result follows once the last filled entry
// has been compared; busy is high meanwhile.
//
// Reset (rst, synchronous) empties the table and returns to idle; table
// contents are not cleared, only the fill count.
module longest_prefix_route_lookup_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [lpr_pkg::IP_W-1:0]      route_net,
  input  logic [lpr_pkg::LEN_W-1:0]     prefix_len,
  input  logic                          has_next_hop,
  input  logic [lpr_pkg::IP_W-1:0]      next_hop_addr,
  input  logic [lpr_pkg::IFACE_W-1:0]   iface_index,
  input  logic [lpr_pkg::IP_W-1:0]      dest_addr,
  input  logic [lpr_pkg::TTL_W-1:0]     ttl_in,
  output logic                          done,
  output logic [lpr_pkg::STAT_W-1:0]    status,
  output logic [lpr_pkg::IFACE_W-1:0]   out_iface,
  output logic [lpr_pkg::IP_W-1:0]      hop_addr,
  output logic [lpr_pkg::TTL_W-1:0]     ttl_out
);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                         state;
  logic [lpr_pkg::CNT_W-1:0]      count;
  logic [lpr_pkg::CNT_W-1:0]      issue_idx;
  logic                           cmp_valid;
  logic [lpr_pkg::IP_W-1:0]       dst;
  logic [lpr_pkg::TTL_W-1:0]      ttl;
  logic                           found;
  logic [lpr_pkg::LEN_W-1:0]      best_len;
  logic                           best_has_hop;
  logic [lpr_pkg::IP_W-1:0]       best_hop;
  logic [lpr_pkg::IFACE_W-1:0]    best_iface;

  logic                           accept;
  logic                           table_full;
  logic                           wr_en;
  lpr_pkg::entry_t                wr_data;
  logic                           rd_en;
  lpr_pkg::entry_t                rd_data;
  logic                           match;
  logic                           better;
  logic                           scan_end;

  assign busy       = (state != IDLE);
  assign accept     = start && !busy;
  assign table_full = (count >= lpr_pkg::CNT_W'(lpr_pkg::TABLE_DEPTH));
  assign wr_en      = accept && (cmd == lpr_pkg::CMD_ADD) && !table_full;

  always_comb begin
    wr_data.prefix   = route_net;
    wr_data.length   = (prefix_len > lpr_pkg::MAX_LEN) ? lpr_pkg::MAX_LEN : prefix_len;
    wr_data.has_hop  = has_next_hop;
    wr_data.hop_addr = next_hop_addr;
    wr_data.iface    = iface_index;
  end

  assign rd_en    = (state == SCAN) && (issue_idx < count);
  assign scan_end = (state == SCAN) && !rd_en && !cmp_valid;

  // shared compare unit, one table entry per cycle
  assign match  = ((dst ^ rd_data.prefix) & lpr_pkg::len_mask(rd_data.length)) == '0;
  assign better = cmp_valid && match && (!found || (rd_data.length > best_len));

  lpr_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[lpr_pkg::ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[lpr_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      issue_idx <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= 1'b0;
      cmp_valid <= rd_en;
      if (rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (better) begin
        found        <= 1'b1;
        best_len     <= rd_data.length;
        best_has_hop <= rd_data.has_hop;
        best_hop     <= rd_data.hop_addr;
        best_iface   <= rd_data.iface;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            out_iface <= '0;
            hop_addr  <= '0;
            ttl_out   <= '0;
            if (cmd == lpr_pkg::CMD_ADD) begin
              done <= 1'b1;
              if (table_full) begin
                status <= lpr_pkg::ST_FULL;
              end else begin
                status <= lpr_pkg::ST_ADDED;
                count  <= count + 1'b1;
              end
            end else if (ttl_in < lpr_pkg::MIN_TTL) begin
              done   <= 1'b1;
              status <= lpr_pkg::ST_DROP_TTL;
            end else begin
              dst       <= dest_addr;
              ttl       <= ttl_in;
              issue_idx <= '0;
              cmp_valid <= 1'b0;
              found     <= 1'b0;
              state     <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan_end) begin
            done  <= 1'b1;
            state <= IDLE;
            if (found && (int'(best_iface) < lpr_pkg::NUM_IFACES)) begin
              status    <= lpr_pkg::ST_FORWARDED;
              out_iface <= best_iface;
              hop_addr  <= best_has_hop ? best_hop : dst;
              ttl_out   <= ttl - 1'b1;
            end else begin
              status <= lpr_pkg::ST_DROP_NOROUTE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/lpr_checker.sv
module lpr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          cmd,
  input logic [lpr_pkg::TTL_W-1:0]     ttl_in,
  input logic                          done,
  input logic [lpr_pkg::STAT_W-1:0]    status,
  input logic [lpr_pkg::IFACE_W-1:0]   out_iface,
  input logic [lpr_pkg::IP_W-1:0]      hop_addr,
  input logic [lpr_pkg::TTL_W-1:0]     ttl_out
);

  // result always lands in idle, so a new command can follow at once
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == lpr_pkg::CMD_ADD)) |=>
      (done && ((status == lpr_pkg::ST_ADDED) || (status == lpr_pkg::ST_FULL))))
    else $error("add transaction did not complete in one cycle");

  a_ttl_drop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == lpr_pkg::CMD_ROUTE) && (ttl_in < lpr_pkg::MIN_TTL)) |=>
      (done && (status == lpr_pkg::ST_DROP_TTL) && (ttl_out == '0)))
    else $error("low TTL not dropped");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == lpr_pkg::CMD_ROUTE) && (ttl_in >= lpr_pkg::MIN_TTL)) |=>
      (busy && !done))
    else $error("lookup did not start a scan");

  a_no_fwd_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != lpr_pkg::ST_FORWARDED)) |->
      ((out_iface == '0) && (hop_addr == '0) && (ttl_out == '0)))
    else $error("non-forwarded result carries route data");

endmodule

bind longest_prefix_route_lookup_core lpr_checker u_lpr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .ttl_in    (ttl_in),
  .done      (done),
  .status    (status),
  .out_iface (out_iface),
  .hop_addr  (hop_addr),
  .ttl_out   (ttl_out)
);

>>> tb/longest_prefix_route_lookup_core_test.sv
module longest_prefix_route_lookup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        cmd;
    logic [lpr_pkg::IP_W-1:0]    route_net;
    logic [lpr_pkg::LEN_W-1:0]   prefix_len;
    logic                        has_next_hop;
    logic [lpr_pkg::IP_W-1:0]    next_hop_addr;
    logic [lpr_pkg::IFACE_W-1:0] iface_index;
    logic [lpr_pkg::IP_W-1:0]    dest_addr;
    logic [lpr_pkg::TTL_W-1:0]   ttl_in;
  } route_req_t;

  typedef struct packed {
    lpr_pkg::status_t            status;
    logic [lpr_pkg::IFACE_W-1:0] iface;
    logic [lpr_pkg::IP_W-1:0]    hop;
    logic [lpr_pkg::TTL_W-1:0]   ttl;
  } verdict_t;

  class lpm_checker;
    logic [lpr_pkg::CNT_W-1:0]   fill;
    logic [lpr_pkg::IP_W-1:0]    net_prefix[lpr_pkg::TABLE_DEPTH];
    logic [lpr_pkg::LEN_W-1:0]   net_len[lpr_pkg::TABLE_DEPTH];
    logic                        net_has_hop[lpr_pkg::TABLE_DEPTH];
    logic [lpr_pkg::IP_W-1:0]    net_hop[lpr_pkg::TABLE_DEPTH];
    logic [lpr_pkg::IFACE_W-1:0] net_iface[lpr_pkg::TABLE_DEPTH];
    verdict_t                    pending_verdicts[$];
    int                          errors;
    int                          tally[5];

    function new();
      fill   = '0;
      errors = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    static function logic [lpr_pkg::IP_W-1:0] net_mask(input logic [lpr_pkg::LEN_W-1:0] len);
      if (len == 0) return '0;
      return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function verdict_t forward_decision(input route_req_t r);
      verdict_t                  v;
      logic [lpr_pkg::LEN_W-1:0] len;
      bit                        found;
      int                        best;
      logic [lpr_pkg::LEN_W-1:0] best_len;
      v = '{status: lpr_pkg::ST_ADDED, iface: '0, hop: '0, ttl: '0};
      if (r.cmd == lpr_pkg::CMD_ADD) begin
        if (fill >= lpr_pkg::TABLE_DEPTH) begin
          v.status = lpr_pkg::ST_FULL;
        end else begin
          len = (r.prefix_len > lpr_pkg::MAX_LEN) ? lpr_pkg::MAX_LEN : r.prefix_len;
          net_prefix[fill]  = r.route_net;
          net_len[fill]     = len;
          net_has_hop[fill] = r.has_next_hop;
          net_hop[fill]     = r.next_hop_addr;
          net_iface[fill]   = r.iface_index;
          fill++;
        end
      end else if (r.ttl_in < lpr_pkg::MIN_TTL) begin
        v.status = lpr_pkg::ST_DROP_TTL;
      end else begin
        found    = 0;
        best     = 0;
        best_len = '0;
        for (int i = 0; i < int'(fill); i++) begin
          if (((r.dest_addr ^ net_prefix[i]) & net_mask(net_len[i])) == 0) begin
            if (!found || net_len[i] > best_len) begin
              found    = 1;
              best     = i;
              best_len = net_len[i];
            end
          end
        end
        if (!found || int'(net_iface[best]) >= lpr_pkg::NUM_IFACES) begin
          v.status = lpr_pkg::ST_DROP_NOROUTE;
        end else begin
          v.status = lpr_pkg::ST_FORWARDED;
          v.iface  = net_iface[best];
          v.hop    = net_has_hop[best] ? net_hop[best] : r.dest_addr;
          v.ttl    = r.ttl_in - 1'b1;
        end
      end
      return v;
    endfunction

    function void note(input route_req_t r);
      verdict_t v;
      v = forward_decision(r);
      pending_verdicts.insert(pending_verdicts.size(), v);
      tally[v.status]++;
    endfunction

    function void check(input verdict_t act);
      verdict_t exp;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result status=%0d iface=%0d hop=%h ttl=%0d",
                   $realtime, act.status, act.iface, act.hop, act.ttl);
        return;
      end
      exp = pending_verdicts.pop_front();
      if (act.status !== exp.status || act.iface !== exp.iface ||
          act.hop !== exp.hop || act.ttl !== exp.ttl) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: result mismatch exp status=%0d iface=%0d hop=%h ttl=%0d,",
                    " got status=%0d iface=%0d hop=%h ttl=%0d"},
                   $realtime, exp.status, exp.iface, exp.hop, exp.ttl,
                   act.status, act.iface, act.hop, act.ttl);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        cmd = lpr_pkg::CMD_ADD;
  logic [lpr_pkg::IP_W-1:0]    route_net = '0;
  logic [lpr_pkg::LEN_W-1:0]   prefix_len = '0;
  logic                        has_next_hop = 1'b0;
  logic [lpr_pkg::IP_W-1:0]    next_hop_addr = '0;
  logic [lpr_pkg::IFACE_W-1:0] iface_index = '0;
  logic [lpr_pkg::IP_W-1:0]    dest_addr = '0;
  logic [lpr_pkg::TTL_W-1:0]   ttl_in = '0;
  logic                        done;
  logic [lpr_pkg::STAT_W-1:0]  status;
  logic [lpr_pkg::IFACE_W-1:0] out_iface;
  logic [lpr_pkg::IP_W-1:0]    hop_addr;
  logic [lpr_pkg::TTL_W-1:0]   ttl_out;

  lpm_checker sb = new();

  logic [lpr_pkg::IP_W-1:0]  known_prefix[$];
  logic [lpr_pkg::LEN_W-1:0] known_len[$];
  bit                        quiet = 0;

  longest_prefix_route_lookup_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .route_net    (route_net),
    .prefix_len   (prefix_len),
    .has_next_hop (has_next_hop),
    .next_hop_addr(next_hop_addr),
    .iface_index  (iface_index),
    .dest_addr    (dest_addr),
    .ttl_in       (ttl_in),
    .done         (done),
    .status       (status),
    .out_iface    (out_iface),
    .hop_addr     (hop_addr),
    .ttl_out      (ttl_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check(verdict_t'({status, out_iface, hop_addr, ttl_out}));
      if (start && !busy)
        sb.note(route_req_t'({cmd, route_net, prefix_len, has_next_hop,
                              next_hop_addr, iface_index, dest_addr, ttl_in}));
    end
  end

  function automatic route_req_t rand_req();
    route_req_t r;
    r.cmd           = 1'($urandom_range(0, 1));
    r.route_net     = $urandom();
    r.prefix_len    = lpr_pkg::LEN_W'($urandom_range(0, 63));
    r.has_next_hop  = 1'($urandom_range(0, 1));
    r.next_hop_addr = $urandom();
    r.iface_index   = lpr_pkg::IFACE_W'($urandom_range(0, 15));
    r.dest_addr     = $urandom();
    r.ttl_in        = lpr_pkg::TTL_W'($urandom_range(0, 255));
    return r;
  endfunction

  // mostly addresses inside a known net, some just outside it
  function automatic logic [lpr_pkg::IP_W-1:0] pick_dest();
    int                       k;
    int                       bitpos;
    logic [lpr_pkg::IP_W-1:0] m;
    logic [lpr_pkg::IP_W-1:0] d;
    if (known_prefix.size() == 0 || $urandom_range(0, 3) == 0) return $urandom();
    k = $urandom_range(0, known_prefix.size() - 1);
    m = lpm_checker::net_mask(known_len[k]);
    d = (known_prefix[k] & m) | ($urandom() & ~m);
    if (known_len[k] != 0 && $urandom_range(0, 4) == 0) begin
      bitpos = 32 - int'($urandom_range(1, known_len[k]));
      d[bitpos] = ~d[bitpos];
    end
    return d;
  endfunction

  task automatic send_req(input route_req_t r);
    cmd           <= r.cmd;
    route_net     <= r.route_net;
    prefix_len    <= r.prefix_len;
    has_next_hop  <= r.has_next_hop;
    next_hop_addr <= r.next_hop_addr;
    iface_index   <= r.iface_index;
    dest_addr     <= r.dest_addr;
    ttl_in        <= r.ttl_in;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pace(input bit allow);
    if (allow && !quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic issue(input route_req_t r, input bit allow_gap);
    if (r.cmd == lpr_pkg::CMD_ADD && known_prefix.size() < lpr_pkg::TABLE_DEPTH) begin
      known_prefix.insert(known_prefix.size(), r.route_net);
      known_len.insert(known_len.size(),
                       (r.prefix_len > lpr_pkg::MAX_LEN) ? lpr_pkg::MAX_LEN : r.prefix_len);
    end
    send_req(r);
    pace(allow_gap);
  endtask

  task automatic install_route(input logic [lpr_pkg::IP_W-1:0] pfx,
                               input logic [lpr_pkg::LEN_W-1:0] len,
                               input logic hh, input logic [lpr_pkg::IP_W-1:0] hop,
                               input logic [lpr_pkg::IFACE_W-1:0] ifc);
    route_req_t r;
    r               = rand_req();
    r.cmd           = lpr_pkg::CMD_ADD;
    r.route_net     = pfx;
    r.prefix_len    = len;
    r.has_next_hop  = hh;
    r.next_hop_addr = hop;
    r.iface_index   = ifc;
    issue(r, 1'b1);
  endtask

  task automatic route_pkt(input logic [lpr_pkg::IP_W-1:0] dst,
                           input logic [lpr_pkg::TTL_W-1:0] ttl);
    route_req_t r;
    r           = rand_req();
    r.cmd       = lpr_pkg::CMD_ROUTE;
    r.dest_addr = dst;
    r.ttl_in    = ttl;
    issue(r, 1'b1);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin
    route_req_t                r;
    int                        k;
    logic [lpr_pkg::LEN_W-1:0] l;
    logic [lpr_pkg::IP_W-1:0]  m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, TTL limits
    route_pkt(32'h0A01_0203, 8'd200);
    route_pkt(32'h0A01_0203, 8'd0);
    route_pkt(32'h0A01_0203, 8'd1);
    install_route(32'h0A00_0000, 6'd8,  1'b1, 32'h0102_0304, 4'd3);
    install_route(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd15);
    install_route(32'h0A01_0203, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd0);
    install_route(32'hC0A8_0000, 6'd33, 1'b1, 32'h0000_0001, 4'd7);
    install_route(32'hC0A8_0000, 6'd16, 1'b0, 32'h0000_0000, 4'd8);
    // same net twice: earlier entry must win
    install_route(32'hAC10_0000, 6'd12, 1'b1, 32'h1111_1111, 4'd1);
    install_route(32'hAC10_0000, 6'd12, 1'b1, 32'h2222_2222, 4'd2);
    install_route(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 4'd5);
    install_route(32'h8000_0000, 6'd1,  1'b0, 32'h5555_5555, 4'd9);
    route_pkt(32'h0A01_0203, 8'd255);
    route_pkt(32'h0A01_0204, 8'd2);
    route_pkt(32'h0AC8_0001, 8'd64);
    route_pkt(32'hC0A8_0000, 8'd10);
    route_pkt(32'hC0A8_FF01, 8'd10);
    route_pkt(32'hAC1F_0001, 8'd33);
    route_pkt(32'hFFFF_FFFF, 8'd128);
    route_pkt(32'h8000_0001, 8'd3);
    route_pkt(32'h0000_0001, 8'd99);
    route_pkt(32'h0A01_0203, 8'd1);
    drain();

    for (int n = 0; n < 1450; n++) begin
      if (n % 60 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == 500) drain();
      r = rand_req();
      if (known_prefix.size() < lpr_pkg::TABLE_DEPTH - 1)
        r.cmd = ($urandom_range(0, 23) == 0) ? lpr_pkg::CMD_ADD : lpr_pkg::CMD_ROUTE;
      else if (known_prefix.size() == lpr_pkg::TABLE_DEPTH - 1)
        r.cmd = (n >= 1000) ? lpr_pkg::CMD_ADD : lpr_pkg::CMD_ROUTE;
      else
        r.cmd = ($urandom_range(0, 19) == 0) ? lpr_pkg::CMD_ADD : lpr_pkg::CMD_ROUTE;

      if (r.cmd == lpr_pkg::CMD_ADD) begin
        if (known_prefix.size() == lpr_pkg::TABLE_DEPTH - 1) begin
          r.prefix_len = '0;  // default route goes in last
        end else if (known_prefix.size() < lpr_pkg::TABLE_DEPTH - 1) begin
          if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, known_prefix.size() - 1);
            if ($urandom_range(0, 3) == 0) begin
              r.route_net  = known_prefix[k];
              r.prefix_len = (known_len[k] == 0) ? 6'd1 : known_len[k];
            end else begin
              l = (known_len[k] == 0) ? 6'd1 : known_len[k];
              m = lpm_checker::net_mask(l);
              r.route_net  = (known_prefix[k] & m) | ($urandom() & ~m);
              r.prefix_len = lpr_pkg::LEN_W'($urandom_range(l, 32));
            end
          end else begin
            r.prefix_len = lpr_pkg::LEN_W'($urandom_range(1, 63));
          end
        end
      end else begin
        r.dest_addr = pick_dest();
        case ($urandom_range(0, 11))
          0:       r.ttl_in = lpr_pkg::TTL_W'($urandom_range(0, 1));
          1:       r.ttl_in = 8'd255;
          2:       r.ttl_in = lpr_pkg::MIN_TTL;
          default: r.ttl_in = lpr_pkg::TTL_W'($urandom_range(2, 255));
        endcase
      end
      issue(r, n < 1300);
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered: %0d routes added, %0d adds refused on a full table",
             sb.tally[lpr_pkg::ST_ADDED], sb.tally[lpr_pkg::ST_FULL]);
    $display("covered: %0d forwarded, %0d TTL drops, %0d no-route drops, %0d errors",
             sb.tally[lpr_pkg::ST_FORWARDED], sb.tally[lpr_pkg::ST_DROP_TTL],
             sb.tally[lpr_pkg::ST_DROP_NOROUTE], sb.errors);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
